### rtl/core/ede_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_pkg
// Types and constants shared by the edit distance engine and its cells.
// ----------------------------------------------------------------------------
package ede_pkg;

	localparam int SYM_W  = 16;
	localparam int DIST_W = 7;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_QUERY  = 2'd1,
		OP_REPORT = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t              operation;
		logic [SYM_W-1:0] symbol;
	} in_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} out_word_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic             append;
		logic             clear;
		logic [SYM_W-1:0] symbol;
	} cell_ctl_t;

	// query wave handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] symbol;
	} wave_t;

endpackage

### rtl/core/ede_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_cell
// One column entry of the edit distance row: holds one reference word and
// its distance, updates it when a query wave passes and hands the wave on.
// ----------------------------------------------------------------------------
module ede_cell #(
	parameter int MAX_LEN = 64,
	parameter int INDEX   = 1,
	parameter int LW      = $clog2(MAX_LEN + 1),
	parameter int DW      = $clog2(MAX_LEN + 2)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LW-1:0]      ref_len,
	input  ede_pkg::cell_ctl_t ctl,
	input  ede_pkg::wave_t     wave_in,
	input  logic [DW-1:0]      new_in,
	input  logic [DW-1:0]      old_in,
	output ede_pkg::wave_t     wave_out,
	output logic [DW-1:0]      new_out,
	output logic [DW-1:0]      old_out
);
	import ede_pkg::*;

	logic [SYM_W-1:0] char_q;
	logic [DW-1:0]    dist_q;
	logic             wave_vld_q;
	logic [SYM_W-1:0] wave_sym_q;
	logic [DW-1:0]    new_q;
	logic [DW-1:0]    old_q;
	logic             active;
	logic             load;
	logic [DW-1:0]    cand_up;
	logic [DW-1:0]    cand_left;
	logic [DW-1:0]    cand_diag;
	logic [DW-1:0]    best;

	assign active = LW'(INDEX) <= ref_len;
	assign load   = ctl.append && (ref_len == LW'(INDEX - 1));

	assign cand_up   = dist_q + DW'(1);
	assign cand_left = new_in + DW'(1);
	assign cand_diag = old_in + DW'(char_q != wave_in.symbol);

	always_comb begin
		best = cand_up;
		if (cand_left < best) begin
			best = cand_left;
		end
		if (cand_diag < best) begin
			best = cand_diag;
		end
	end

	// reference word, undefined until written
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= ctl.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q     <= DW'(INDEX);
			wave_vld_q <= 1'b0;
		end else begin
			wave_vld_q <= wave_in.valid;
			if (ctl.clear) begin
				dist_q <= DW'(INDEX);
			end else if (wave_in.valid && active) begin
				dist_q <= best;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wave_in.valid) begin
			wave_sym_q <= wave_in.symbol;
			new_q      <= active ? best : new_in;
			old_q      <= dist_q;
		end
	end

	assign wave_out = '{valid: wave_vld_q, symbol: wave_sym_q};
	assign new_out  = new_q;
	assign old_out  = old_q;

endmodule

### rtl/core/edit_distance_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein distance between a stored reference string and a query string
// of 16-bit words, computed by a row of MAX_LEN cells.
// ----------------------------------------------------------------------------
// Append and query words are taken one per cycle. Each query word starts a
// wave that moves one cell per cycle along the row of MAX_LEN cells, so a
// report word waits until the last query wave has left the row, and its
// distance is then registered in the result register. The result register
// lets append and query words in while a result waits.
module edit_distance_engine #(
	parameter int MAX_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  ede_pkg::in_word_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output ede_pkg::out_word_t  result
);
	import ede_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int DW = $clog2(MAX_LEN + 2);
	localparam int BW = $clog2(MAX_LEN + 3);

	logic [LW-1:0] ref_len_q;
	logic [LW-1:0] q_len_q;
	logic          ovf_q;
	logic [BW-1:0] busy_q;
	logic [DW-1:0] dist_q;
	logic          res_valid_q;
	out_word_t     res_q;

	logic          acc;
	logic          acc_append;
	logic          acc_query;
	logic          acc_report;
	logic          append_ok;
	logic          query_ok;
	logic          out_free;
	cell_ctl_t     ctl;
	logic [DW-1:0] final_dist;

	wave_t         wave_w [0:MAX_LEN];
	logic [DW-1:0] new_w  [0:MAX_LEN];
	logic [DW-1:0] old_w  [0:MAX_LEN];
	logic             wave0_vld_q;
	logic [SYM_W-1:0] wave0_sym_q;
	logic [DW-1:0] new0_q;
	logic [DW-1:0] old0_q;

	assign out_free   = !res_valid_q || !result_stall;
	assign item_stall = (item.operation == OP_REPORT) && ((busy_q != '0) || !out_free);

	assign acc        = item_valid && !item_stall;
	assign acc_append = acc && (item.operation == OP_APPEND);
	assign acc_query  = acc && (item.operation == OP_QUERY);
	assign acc_report = acc && (item.operation == OP_REPORT);

	assign append_ok = (q_len_q == '0) && (ref_len_q != LW'(MAX_LEN));
	assign query_ok  = q_len_q != LW'(MAX_LEN);

	assign ctl.append = acc_append && append_ok;
	assign ctl.clear  = acc_report;
	assign ctl.symbol = item.symbol;

	// with no query word the distance is the reference length
	assign final_dist = (q_len_q == '0) ? DW'(ref_len_q) : dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q   <= '0;
			q_len_q     <= '0;
			ovf_q       <= 1'b0;
			busy_q      <= '0;
			res_valid_q <= 1'b0;
			wave0_vld_q <= 1'b0;
		end else begin
			wave0_vld_q <= acc_query && query_ok;
			if (acc_query && query_ok) begin
				busy_q <= BW'(MAX_LEN + 2);
			end else if (busy_q != '0) begin
				busy_q <= busy_q - BW'(1);
			end
			if (acc_report) begin
				ref_len_q <= '0;
				q_len_q   <= '0;
				ovf_q     <= 1'b0;
			end else begin
				if (acc_append) begin
					if (append_ok) begin
						ref_len_q <= ref_len_q + LW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				if (acc_query) begin
					if (query_ok) begin
						q_len_q <= q_len_q + LW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (acc_report) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_query) begin
			wave0_sym_q <= item.symbol;
			new0_q      <= DW'(q_len_q) + DW'(1);
			old0_q      <= DW'(q_len_q);
		end
		if (wave_w[MAX_LEN].valid) begin
			dist_q <= new_w[MAX_LEN];
		end
		if (acc_report) begin
			res_q.distance <= DIST_W'(final_dist);
			res_q.overflow <= ovf_q;
		end
	end

	assign wave_w[0] = '{valid: wave0_vld_q, symbol: wave0_sym_q};
	assign new_w[0]  = new0_q;
	assign old_w[0]  = old0_q;

	for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
		ede_cell #(
			.MAX_LEN(MAX_LEN),
			.INDEX  (i),
			.LW     (LW),
			.DW     (DW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ref_len (ref_len_q),
			.ctl     (ctl),
			.wave_in (wave_w[i-1]),
			.new_in  (new_w[i-1]),
			.old_in  (old_w[i-1]),
			.wave_out(wave_w[i]),
			.new_out (new_w[i]),
			.old_out (old_w[i])
		);
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_report_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		acc_report |=> result_valid)
		else $error("report word accepted without a result");

	a_ref_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(q_len_q != '0 && !acc_report) |=> ref_len_q == $past(ref_len_q))
		else $error("reference grew after query words");

	a_wave_covered: assert property (@(posedge clk) disable iff (!arst_n)
		wave_w[MAX_LEN].valid |-> busy_q != '0)
		else $error("query wave still in the row while idle");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ref_len_q <= LW'(MAX_LEN) && q_len_q <= LW'(MAX_LEN))
		else $error("string length beyond row size");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for edit_distance_engine. Reference and query strings
// are streamed in as append and query words, and each report word's distance
// and overflow flag are predicted in the bench and checked in order. Both
// channels idle and stall at random, and one long receiver hold-off fills the
// block until it stalls its input.
// ----------------------------------------------------------------------------
module testbench;
	import ede_pkg::*;

	localparam int MAX_LEN      = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = MAX_LEN + 8;
	localparam int RANDOM_WORDS = 860;

	typedef enum int {
		RX_READY,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_word_t  item;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result;

	// distance predictor state
	logic [SYM_W-1:0] ref_sym [MAX_LEN];
	int               dp_col [MAX_LEN+1];
	int               ref_len;
	int               qry_len;
	logic             ovf_seen;
	out_word_t        dist_expected [$];
	logic [SYM_W-1:0] alphabet [4];

	int       words_sent       = 0;
	int       reports_checked  = 0;
	int       overflow_reports = 0;
	int       mismatches       = 0;
	int       burst_left       = 0;
	int       idle_cycles      = 0;
	int       mode_cycles      = 0;
	rx_mode_t rx_mode          = RX_READY;
	logic     hold_on          = 1'b0;
	event     start_hold;

	edit_distance_engine #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_strings();
		for (int y = 0; y <= MAX_LEN; y++)
			dp_col[y] = y;
		ref_len  = 0;
		qry_len  = 0;
		ovf_seen = 1'b0;
	endfunction

	function automatic void predict_distance(in_word_t w);
		int        diag;
		int        prev;
		int        best;
		int        subst;
		out_word_t r;
		case (w.operation)
		OP_APPEND: begin
			if (qry_len != 0 || ref_len >= MAX_LEN) begin
				ovf_seen = 1'b1;
			end else begin
				ref_sym[ref_len] = w.symbol;
				ref_len++;
			end
		end
		OP_QUERY: begin
			if (qry_len >= MAX_LEN) begin
				ovf_seen = 1'b1;
			end else begin
				diag = dp_col[0];
				dp_col[0] = qry_len + 1;
				for (int y = 1; y <= ref_len; y++) begin
					prev  = dp_col[y];
					subst = diag + ((ref_sym[y-1] == w.symbol) ? 0 : 1);
					best  = prev + 1;
					if (dp_col[y-1] + 1 < best)
						best = dp_col[y-1] + 1;
					if (subst < best)
						best = subst;
					dp_col[y] = best;
					diag = prev;
				end
				qry_len++;
			end
		end
		OP_REPORT: begin
			r.distance = DIST_W'(dp_col[ref_len]);
			r.overflow = ovf_seen;
			dist_expected.push_back(r);
			clear_strings();
		end
		default: begin
		end
		endcase
	endfunction

	function automatic logic [SYM_W-1:0] pick_symbol();
		if ($urandom_range(4) == 0)
			return SYM_W'($urandom);
		return alphabet[$urandom_range(3)];
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return $urandom_range(10);
		if (r < 97)
			return $urandom_range(40, 11);
		return $urandom_range(MAX_LEN + 3, MAX_LEN - 3);
	endfunction

	task automatic send_word(input op_t op, input logic [SYM_W-1:0] sym);
		int       gap;
		in_word_t w;
		w.operation = op;
		w.symbol    = sym;
		if (burst_left == 0) begin
			if ($urandom_range(3) == 0) begin
				burst_left = 60;
				gap = 0;
			end else begin
				burst_left = $urandom_range(16, 1);
				gap = $urandom_range(6);
			end
			if (gap != 0) begin
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		predict_distance(w);
		words_sent++;
	endtask

	task automatic send_pair(input int n_ref, input int n_qry, input bit noisy);
		for (int i = 0; i < 4; i++)
			alphabet[i] = SYM_W'($urandom);
		for (int i = 0; i < n_ref; i++)
			send_word(OP_APPEND, pick_symbol());
		for (int i = 0; i < n_qry; i++)
			send_word(OP_QUERY, pick_symbol());
		if (noisy)
			send_word(op_t'($urandom_range(3)), SYM_W'($urandom));
		send_word(OP_REPORT, SYM_W'($urandom));
	endtask

	task automatic test_directed();
		// both empty
		send_word(OP_REPORT, 16'h0000);
		// query empty
		send_word(OP_APPEND, 16'h0000);
		send_word(OP_APPEND, 16'hFFFF);
		send_word(OP_APPEND, 16'h1234);
		send_word(OP_REPORT, 16'hFFFF);
		// reference empty
		send_word(OP_QUERY, 16'hFFFF);
		send_word(OP_QUERY, 16'h0000);
		send_word(OP_REPORT, 16'h0000);
		// swapped pair
		send_word(OP_APPEND, 16'h0000);
		send_word(OP_APPEND, 16'hFFFF);
		send_word(OP_QUERY, 16'hFFFF);
		send_word(OP_QUERY, 16'h0000);
		send_word(OP_REPORT, 16'h0000);
		// unused op and late append
		send_word(OP_APPEND, 16'hAAAA);
		send_word(OP_QUERY, 16'h5555);
		send_word(OP_NONE, 16'hFFFF);
		send_word(OP_APPEND, 16'h5555);
		send_word(OP_REPORT, 16'h0000);
		// exact match
		send_word(OP_APPEND, 16'hBEEF);
		send_word(OP_QUERY, 16'hBEEF);
		send_word(OP_REPORT, 16'h0000);
	endtask

	task automatic test_string_limits();
		for (int i = 0; i < MAX_LEN + 2; i++)
			send_word(OP_APPEND, SYM_W'(i * 16'h0101));
		for (int i = 0; i < MAX_LEN + 2; i++)
			send_word(OP_QUERY, SYM_W'(i * 16'h0101));
		send_word(OP_REPORT, 16'h0000);
		for (int i = 0; i < MAX_LEN + 1; i++)
			send_word(OP_QUERY, SYM_W'($urandom));
		send_word(OP_REPORT, 16'h0000);
	endtask

	task automatic test_random();
		int stop_at;
		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at)
			send_pair(pick_len(), pick_len(), $urandom_range(6) == 0);
	endtask

	task automatic test_backpressure();
		burst_left = 100000;
		-> start_hold;
		for (int i = 0; i < 30; i++)
			send_pair($urandom_range(3), $urandom_range(3), 1'b0);
		burst_left = 0;
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (mode_cycles == 0) begin
			rx_mode = rx_mode_t'($urandom_range(3));
			mode_cycles = $urandom_range(300, 50);
		end
		mode_cycles--;
		if (hold_on)
			result_stall <= 1'b1;
		else case (rx_mode)
			RX_READY:    result_stall <= 1'b0;
			RX_LIGHT:    result_stall <= ($urandom_range(3) == 0);
			RX_HEAVY:    result_stall <= ($urandom_range(3) != 0);
			default:     result_stall <= (mode_cycles % 3 == 0);
		endcase
	end

	// long receiver hold-off
	always @(start_hold) begin
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (dist_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: distance %0d overflow %0b",
						result.distance, result.overflow);
			end else begin
				want = dist_expected.pop_front();
				if (result.distance !== want.distance || result.overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: distance %0d/%0d overflow %0b/%0b (exp/got)",
							want.distance, result.distance, want.overflow, result.overflow);
				end
				reports_checked++;
				if (want.overflow)
					overflow_reports++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		clear_strings();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_string_limits();
		test_random();
		test_backpressure();

		@(negedge clk);
		item_valid <= 1'b0;
		while (dist_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words and %0d reports (%0d flagged), incl. full strings",
			words_sent, reports_checked, overflow_reports);
		$display("and a %0d-cycle receiver hold-off; %0d mismatches", HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/core/ede_pkg.sv
rtl/core/ede_cell.sv
rtl/core/edit_distance_engine.sv
tb/testbench.sv
